// ===== hw/rtl/leb_pkg.sv =====
`default_nettype none
package leb_pkg;

  localparam int CAPACITY = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CHAR_W   = 8;
  localparam int TEXT_W   = 7;

  localparam logic [CHAR_W-1:0] PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'd126;

  localparam logic [2:0] OP_HOME  = 3'd0;
  localparam logic [2:0] OP_END   = 3'd1;
  localparam logic [2:0] OP_LEFT  = 3'd2;
  localparam logic [2:0] OP_RIGHT = 3'd3;
  localparam logic [2:0] OP_TYPE  = 3'd4;
  localparam logic [2:0] OP_ERASE = 3'd5;
  localparam logic [2:0] OP_PRINT = 3'd6;
  localparam logic [2:0] OP_NONE  = 3'd7;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [TEXT_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic              char_valid;
    logic              accepted;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [CNT_W-1:0] cur;
    logic             idle;
  } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/line_edit_buffer.sv =====
`default_nettype none
// One-line text buffer with a cursor, driven by key events on the input
// channel (in_valid / in_stall, fields op and char_in). Results leave on the
// output channel (out_valid / out_stall) as words of char_out, char_valid,
// accepted and last; last marks the final word of one event.
// Home, end, left, right, type, erase and unused codes give one word, shown
// in the cycle after the event is taken. An accepted type or erase then
// shifts the stored text one entry per cycle through the single-port-write
// text memory, moving the entries from the cursor to the end of the text,
// and the next event is taken only once the shift is done.
// Print gives one word per stored byte plus one for a nonzero separator;
// each byte is read from the text memory in the read state S_PRRD and
// shown from the emit state S_PREM once the registered read has returned;
// the separator is shown from S_PREM with no read of its own.
// An empty print with no separator gives one word with accepted set.
// Reset clears length and cursor; the text memory is not cleared, since only
// entries below the length are ever read. When the receiver stalls, the
// output word holds and the block stops taking events and printing.
module line_edit_buffer
  import leb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic        [2:0] op,
  input  wire logic [CHAR_W-1:0] char_in,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [CHAR_W-1:0] char_out,
  output logic                   char_valid,
  output logic                   accepted,
  output logic                   last
);

  logic              slot_free;
  logic              emit;
  res_t              res;
  mem_req_t          mem_req;
  logic [TEXT_W-1:0] rd_data;
  status_t           status;

  // output word register can load when empty or being taken this cycle
  assign slot_free = !out_valid || !out_stall;

  leb_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .char_in   (char_in),
    .slot_free (slot_free),
    .emit      (emit),
    .res       (res),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .status    (status)
  );

  leb_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // hold the word while stalled, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_out   <= res.char_out;
      char_valid <= res.char_valid;
      accepted   <= res.accepted;
      last       <= res.last;
    end
  end

  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    status.cur <= status.len)
    else $error("cursor beyond text length");

  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    status.len <= CNT_W'(CAPACITY))
    else $error("text length beyond capacity");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> in_stall)
    else $error("event taken while output word is stalled");

  a_byte_is_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_valid) |-> accepted)
    else $error("printed word without accepted flag");

endmodule
`default_nettype wire

// ===== hw/rtl/leb_mem.sv =====
`default_nettype none
module leb_mem
  import leb_pkg::*;
(
  input  wire logic              clk,
  input  wire mem_req_t          req,
  output logic      [TEXT_W-1:0] rd_data
);

  logic [TEXT_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/leb_seq.sv =====
`default_nettype none
module leb_seq
  import leb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic        [2:0] op,
  input  wire logic [CHAR_W-1:0] char_in,
  input  wire logic              slot_free,
  output logic                   emit,
  output res_t                   res,
  output mem_req_t               mem_req,
  input  wire logic [TEXT_W-1:0] rd_data,
  output status_t                status
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SHUP = 5'b00010,
    S_SHDN = 5'b00100,
    S_PRRD = 5'b01000,
    S_PREM = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  len, len_next;
  logic [CNT_W-1:0]  cur, cur_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic              pend, pend_next;
  logic [ADDR_W-1:0] waddr, waddr_next;
  logic [CHAR_W-1:0] sep, sep_next;
  logic              sep_done, sep_done_next;
  logic [TEXT_W-1:0] tch, tch_next;

  logic accept;
  logic type_ok;
  logic sep_here;
  logic sep_after;
  logic byte_last;

  assign in_stall = !((state == S_IDLE) && slot_free);
  assign accept   = in_valid && !in_stall;
  assign type_ok  = (char_in >= PRINT_LO) && (char_in <= PRINT_HI) &&
                    (len < CNT_W'(CAPACITY));
  assign sep_here  = (sep != '0) && !sep_done && (idx == cur);
  assign sep_after = (sep != '0) && (cur == len);
  assign byte_last = (CNT_W'(idx + 1'b1) == len) && !sep_after;

  assign status.len  = len;
  assign status.cur  = cur;
  assign status.idle = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    len_next      = len;
    cur_next      = cur;
    idx_next      = idx;
    pend_next     = pend;
    waddr_next    = waddr;
    sep_next      = sep;
    sep_done_next = sep_done;
    tch_next      = tch;
    emit          = 1'b0;
    res           = '0;
    mem_req       = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          emit     = 1'b1;
          res.last = 1'b1;
          case (op)
            OP_HOME: begin
              cur_next     = '0;
              res.accepted = 1'b1;
            end
            OP_END: begin
              cur_next     = len;
              res.accepted = 1'b1;
            end
            OP_LEFT: begin
              if (cur != '0) begin
                cur_next = cur - 1'b1;
              end
              res.accepted = 1'b1;
            end
            OP_RIGHT: begin
              if (cur < len) begin
                cur_next = cur + 1'b1;
              end
              res.accepted = 1'b1;
            end
            OP_TYPE: begin
              res.accepted = type_ok;
              if (type_ok) begin
                idx_next   = len;
                pend_next  = 1'b0;
                tch_next   = char_in[TEXT_W-1:0];
                state_next = S_SHUP;
              end
            end
            OP_ERASE: begin
              res.accepted = (cur != '0);
              if (cur != '0) begin
                idx_next   = cur;
                pend_next  = 1'b0;
                state_next = S_SHDN;
              end
            end
            OP_PRINT: begin
              res.accepted = 1'b1;
              if ((len != '0) || (char_in != '0)) begin
                // streamed from the print states instead
                emit          = 1'b0;
                sep_next      = char_in;
                sep_done_next = 1'b0;
                idx_next      = '0;
                state_next    = S_PRRD;
              end
            end
            default: begin
              res.accepted = 1'b0;
            end
          endcase
        end
      end

      // move entries up one slot, top first; read and write overlap
      S_SHUP: begin
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = waddr;
          mem_req.wr_data = rd_data;
        end
        if (idx > cur) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(idx - 1'b1);
          waddr_next      = ADDR_W'(idx);
          pend_next       = 1'b1;
          idx_next        = idx - 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ADDR_W'(cur);
          mem_req.wr_data = tch;
          len_next        = len + 1'b1;
          cur_next        = cur + 1'b1;
          state_next      = S_IDLE;
        end
      end

      // move entries down one slot, bottom first
      S_SHDN: begin
        if (pend) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = waddr;
          mem_req.wr_data = rd_data;
        end
        if (idx < len) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(idx);
          waddr_next      = ADDR_W'(idx - 1'b1);
          pend_next       = 1'b1;
          idx_next        = idx + 1'b1;
        end else if (pend) begin
          pend_next = 1'b0;
        end else begin
          len_next   = len - 1'b1;
          cur_next   = cur - 1'b1;
          state_next = S_IDLE;
        end
      end

      S_PRRD: begin
        if (idx < len) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = ADDR_W'(idx);
        end
        state_next = S_PREM;
      end

      S_PREM: begin
        if (slot_free) begin
          emit           = 1'b1;
          res.char_valid = 1'b1;
          res.accepted   = 1'b1;
          if (sep_here) begin
            res.char_out  = sep;
            res.last      = (idx == len);
            sep_done_next = 1'b1;
            if (idx == len) begin
              state_next = S_IDLE;
            end
          end else begin
            res.char_out = {1'b0, rd_data};
            res.last     = byte_last;
            idx_next     = idx + 1'b1;
            state_next   = byte_last ? S_IDLE : S_PRRD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      len      <= '0;
      cur      <= '0;
      pend     <= 1'b0;
      sep_done <= 1'b0;
    end else begin
      state    <= state_next;
      len      <= len_next;
      cur      <= cur_next;
      pend     <= pend_next;
      sep_done <= sep_done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    waddr <= waddr_next;
    sep   <= sep_next;
    tch   <= tch_next;
  end

endmodule
`default_nettype wire

// ===== verif/line_edit_checker.sv =====
// Watches both channels of the line buffer, keeps its own copy of the text,
// length and cursor, and compares every output word with the oldest word
// still owed.
module line_edit_checker
  import leb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic        [2:0] op,
  input  logic [CHAR_W-1:0] char_in,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [CHAR_W-1:0] char_out,
  input  logic              char_valid,
  input  logic              accepted,
  input  logic              last,
  output int                errors,
  output int                pending
);

  logic [TEXT_W-1:0] line_text [CAPACITY];
  int                line_len;
  int                cursor;
  res_t              owed_words [$];

  initial begin
    errors   = 0;
    pending  = 0;
    line_len = 0;
    cursor   = 0;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("ERROR at %0t: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  task automatic owe_word(input logic [CHAR_W-1:0] c, input logic v, input logic a,
                          input logic l);
    res_t w;
    w.char_out   = c;
    w.char_valid = v;
    w.accepted   = a;
    w.last       = l;
    owed_words.push_back(w);
  endtask

  // Apply one key event to the local copy and queue the words it must produce.
  task automatic apply_key(input logic [2:0] k, input logic [CHAR_W-1:0] c);
    int   total;
    int   n;
    int   i;
    logic ok;
    ok = 1'b0;
    if (k == OP_PRINT) begin
      total = line_len + ((c != '0) ? 1 : 0);
      if (total == 0) begin
        owe_word('0, 1'b0, 1'b1, 1'b1);
      end else begin
        n = 0;
        for (i = 0; i <= line_len; i++) begin
          if (i == cursor && c != '0) begin
            n++;
            owe_word(c, 1'b1, 1'b1, n == total);
          end
          if (i < line_len) begin
            n++;
            owe_word({1'b0, line_text[i]}, 1'b1, 1'b1, n == total);
          end
        end
      end
    end else begin
      case (k)
        OP_HOME: begin
          cursor = 0;
          ok     = 1'b1;
        end
        OP_END: begin
          cursor = line_len;
          ok     = 1'b1;
        end
        OP_LEFT: begin
          if (cursor > 0) cursor--;
          ok = 1'b1;
        end
        OP_RIGHT: begin
          if (cursor < line_len) cursor++;
          ok = 1'b1;
        end
        OP_TYPE: begin
          if (c >= PRINT_LO && c <= PRINT_HI && line_len < CAPACITY) begin
            for (i = line_len; i > cursor; i--) line_text[i] = line_text[i-1];
            line_text[cursor] = c[TEXT_W-1:0];
            line_len++;
            cursor++;
            ok = 1'b1;
          end
        end
        OP_ERASE: begin
          if (cursor > 0) begin
            for (i = cursor; i < line_len; i++) line_text[i-1] = line_text[i];
            line_len--;
            cursor--;
            ok = 1'b1;
          end
        end
        default: ok = 1'b0;
      endcase
      owe_word('0, 1'b0, ok, 1'b1);
    end
  endtask

  task automatic check_word();
    res_t want;
    if (owed_words.size() == 0) begin
      report("output word with nothing owed", char_out, 0);
    end else begin
      want = owed_words.pop_front();
      if (char_out !== want.char_out)     report("char_out", char_out, want.char_out);
      if (char_valid !== want.char_valid) report("char_valid", char_valid, want.char_valid);
      if (accepted !== want.accepted)     report("accepted", accepted, want.accepted);
      if (last !== want.last)             report("last", last, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_len = 0;
      cursor   = 0;
      owed_words.delete();
    end else begin
      if (in_valid && !in_stall) apply_key(op, char_in);
      if (out_valid && !out_stall) check_word();
    end
    pending <= owed_words.size();
  end

endmodule

// ===== verif/tb_line_edit_buffer.sv =====
// Top of the line buffer bench: makes clock, reset and key events, drives
// random stalls on the output side, and gives the verdict. All checking
// lives in line_edit_checker.
module tb_line_edit_buffer;
  import leb_pkg::*;

  localparam int KEY_TARGET = 370;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic        [2:0] op        = OP_HOME;
  logic [CHAR_W-1:0] char_in   = '0;
  logic              out_stall = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [CHAR_W-1:0] char_out;
  logic              char_valid;
  logic              accepted;
  logic              last;

  int errors;
  int pending;

  // Idling knobs: tx_gappy is only touched by the stimulus process, rx_gappy
  // crosses into the stall process and is therefore written with <=.
  bit tx_gappy   = 1'b0;
  bit rx_gappy   = 1'b0;
  int stall_left = 0;
  int keys_sent  = 0;

  line_edit_buffer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .char_valid (char_valid),
    .accepted   (accepted),
    .last       (last)
  );

  line_edit_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .char_out   (char_out),
    .char_valid (char_valid),
    .accepted   (accepted),
    .last       (last),
    .errors     (errors),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure: mostly short stalls, now and then a long one.
  // While rx_gappy is low no new stall starts; one already begun runs out.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_gappy && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Pick the idle time after a word: none while the sender runs flat out,
  // otherwise mostly short with an occasional long hole.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gappy || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAR_W-1:0] printable();
    return CHAR_W'($urandom_range(PRINT_LO, PRINT_HI));
  endfunction

  // Present one key event, hold it until taken, then maybe idle. Valid stays
  // high across back-to-back words so it is never dropped and raised in the
  // same step. During an idle stretch the payload wanders, valid is low.
  task automatic send_key(input logic [2:0] k, input logic [CHAR_W-1:0] c);
    int gap;
    in_valid <= 1'b1;
    op       <= k;
    char_in  <= c;
    do @(posedge clk); while (in_stall);
    keys_sent++;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      op       <= 3'($urandom);
      char_in  <= CHAR_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every owed word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, sender and receiver both flat out.
    send_key(OP_PRINT, 8'h00);     // print of an empty line, no separator
    send_key(OP_PRINT, 8'h2C);     // empty line, separator alone
    send_key(OP_ERASE, 8'h00);     // erase at the start is refused
    send_key(OP_LEFT,  8'h00);     // left at the left edge
    send_key(OP_RIGHT, 8'h00);     // right at the end of an empty line
    send_key(OP_TYPE,  8'h1F);     // just below the printable range
    send_key(OP_TYPE,  8'h7F);     // just above it
    send_key(OP_TYPE,  8'h00);
    send_key(OP_TYPE,  8'hFF);
    send_key(OP_TYPE,  PRINT_LO);
    send_key(OP_TYPE,  PRINT_HI);
    send_key(OP_TYPE,  8'h41);
    send_key(OP_PRINT, 8'h00);
    send_key(OP_HOME,  8'h00);
    send_key(OP_TYPE,  8'h42);     // insert at the front, shifts the whole line
    send_key(OP_RIGHT, 8'h00);
    send_key(OP_PRINT, 8'h7C);     // separator in the middle
    send_key(OP_END,   8'h00);
    send_key(OP_RIGHT, 8'h00);     // right at the right edge
    send_key(OP_LEFT,  8'h00);
    send_key(OP_ERASE, 8'h00);     // erase in the middle
    send_key(OP_NONE,  8'hFF);     // unused op code
    send_key(OP_PRINT, 8'hFF);     // separator before the last byte, all bits set
    send_key(OP_HOME,  8'h00);
    send_key(OP_ERASE, 8'h00);     // erase at start with text present

    // Let everything drain before the random part.
    wait_drained();
    tx_gappy = 1'b1;
    rx_gappy <= 1'b1;

    while (keys_sent < KEY_TARGET) begin
      pick = $urandom_range(0, 99);
      // Now and then change the idling mode so some stretches run flat out.
      if ($urandom_range(0, 19) == 0) begin
        tx_gappy = ($urandom_range(0, 3) != 0);
        rx_gappy <= ($urandom_range(0, 3) != 0);
      end
      if (pick < 7) begin
        // Type past the capacity so the line fills up, then print it whole.
        repeat (CAPACITY + 2) send_key(OP_TYPE, printable());
        send_key(OP_PRINT, $urandom_range(0, 1) ? 8'h00 : CHAR_W'($urandom_range(1, 255)));
      end else if (pick < 11) begin
        // Wipe part or all of the line from the end.
        send_key(OP_END, CHAR_W'($urandom));
        repeat ($urandom_range(1, CAPACITY + 1)) send_key(OP_ERASE, CHAR_W'($urandom));
      end else if (pick < 14) begin
        send_key(3'($urandom), CHAR_W'($urandom));
      end else if (pick < 16) begin
        wait_drained();
      end else if (pick < 55) begin
        send_key(OP_TYPE, ($urandom_range(0, 9) == 0) ? CHAR_W'($urandom) : printable());
      end else if (pick < 65) begin
        send_key(OP_ERASE, CHAR_W'($urandom));
      end else if (pick < 85) begin
        send_key(3'($urandom_range(OP_HOME, OP_RIGHT)), CHAR_W'($urandom));
      end else if (pick < 98) begin
        send_key(OP_PRINT, $urandom_range(0, 1) ? 8'h00 : CHAR_W'($urandom_range(1, 255)));
      end else begin
        send_key(OP_NONE, CHAR_W'($urandom));
      end
    end

    // Drain, then leave room for a longest shift to show any stray word.
    wait_drained();
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/leb_pkg.sv
hw/rtl/leb_mem.sv
hw/rtl/leb_seq.sv
hw/rtl/line_edit_buffer.sv
verif/line_edit_checker.sv
verif/tb_line_edit_buffer.sv
